/* hdl/s20_pkg.sv */
// shared types, constants and helper functions for the salsa20 128-bit key cipher
// no dependencies; used by s20_core, salsa20_128_stream_cipher and s20_checker

package s20_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_VALUE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_ROUNDS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 3'd4;

    localparam logic [3:0] DOUBLE_ROUNDS_RESET = 4'd10;

    localparam logic [31:0] TAU0 = 32'h61707865;
    localparam logic [31:0] TAU1 = 32'h3120646e;
    localparam logic [31:0] TAU2 = 32'h79622d36;
    localparam logic [31:0] TAU3 = 32'h6b206574;

    // word indexes a, b, c, d of the eight quarter rounds of one double round
    localparam logic [7:0][15:0] QTAB = {
        16'hFCDE, 16'hAB89, 16'h5674, 16'h0123,
        16'hF37B, 16'hAE26, 16'h59D1, 16'h048C
    };

    // rotate amounts of the four quarter round steps
    localparam logic [3:0][4:0] ROT = {5'd18, 5'd13, 5'd9, 5'd7};

    typedef struct packed {
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [63:0] nonce;
        logic [63:0] counter;
        logic [3:0]  rounds;
    } block_cfg_t;

    typedef logic [15:0][31:0] ks_block_t;

    function automatic logic [3:0] qidx(input logic [2:0] q, input logic [1:0] pos);
        logic [15:0] row;
        row = QTAB[q];
        return row[{~pos, 2'b00} +: 4];
    endfunction

    function automatic logic [31:0] init_word(input logic [3:0] idx, input block_cfg_t cfg);
        logic [31:0] w;
        unique case (idx)
            4'd0:    w = TAU0;
            4'd1:    w = cfg.key_low[31:0];
            4'd2:    w = cfg.key_low[63:32];
            4'd3:    w = cfg.key_high[31:0];
            4'd4:    w = cfg.key_high[63:32];
            4'd5:    w = TAU1;
            4'd6:    w = cfg.nonce[31:0];
            4'd7:    w = cfg.nonce[63:32];
            4'd8:    w = cfg.counter[31:0];
            4'd9:    w = cfg.counter[63:32];
            4'd10:   w = TAU2;
            4'd11:   w = cfg.key_low[31:0];
            4'd12:   w = cfg.key_low[63:32];
            4'd13:   w = cfg.key_high[31:0];
            4'd14:   w = cfg.key_high[63:32];
            default: w = TAU3;
        endcase
        return w;
    endfunction

endpackage

/* hdl/s20_arx.sv */
// shared add-rotate-xor unit: x ^ rotl(y + z, rot)
// depends on nothing but its ports

module s20_arx
(
    input  logic [31:0] x,
    input  logic [31:0] y,
    input  logic [31:0] z,
    input  logic [4:0]  rot,
    output logic [31:0] result
);

    logic [31:0] sum;
    logic [5:0]  rinv;

    assign sum    = y + z;
    assign rinv   = 6'd32 - {1'b0, rot};
    assign result = x ^ ((sum << rot) | (sum >> rinv));

endmodule

/* hdl/s20_core.sv */
// keystream block generator: sequencer around the shared add-rotate-xor unit
// depends on s20_pkg and s20_arx

module s20_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  s20_pkg::block_cfg_t cfg,
    output s20_pkg::ks_block_t  ks,
    output logic                done
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_LOAD0,
        ST_LOAD1,
        ST_LOAD2,
        ST_STEP,
        ST_FF_RD,
        ST_FF_WR,
        ST_DONE
    } state_t;

    state_t      state_reg;
    logic [3:0]  idx_reg;
    logic [2:0]  quarter_reg;
    logic [1:0]  step_reg;
    logic [3:0]  round_reg;

    logic [31:0] mem [16];
    logic [31:0] rdata0_reg;
    logic [31:0] rdata1_reg;
    logic [3:0]  raddr0;
    logic [3:0]  raddr1;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;

    logic [31:0] qa_reg;
    logic [31:0] qb_reg;
    logic [31:0] qc_reg;
    logic [31:0] qd_reg;
    s20_pkg::ks_block_t ks_reg;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [31:0] op_z;
    logic [31:0] arx_out;
    logic [1:0]  target;

    assign target = step_reg + 2'd1;
    assign done   = (state_reg == ST_DONE);
    assign ks     = ks_reg;

    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                op_x = qb_reg;
                op_y = qa_reg;
                op_z = qd_reg;
            end
            2'd1:
            begin
                op_x = qc_reg;
                op_y = qb_reg;
                op_z = qa_reg;
            end
            2'd2:
            begin
                op_x = qd_reg;
                op_y = qc_reg;
                op_z = qb_reg;
            end
            default:
            begin
                op_x = qa_reg;
                op_y = qd_reg;
                op_z = qc_reg;
            end
        endcase
    end

    s20_arx u_arx
    (
        .x      (op_x),
        .y      (op_y),
        .z      (op_z),
        .rot    (s20_pkg::ROT[step_reg]),
        .result (arx_out)
    );

    always_comb
    begin
        raddr0    = idx_reg;
        raddr1    = idx_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = s20_pkg::init_word(idx_reg, cfg);
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
            end
            ST_LOAD0:
            begin
                raddr0 = s20_pkg::qidx(quarter_reg, 2'd0);
                raddr1 = s20_pkg::qidx(quarter_reg, 2'd1);
            end
            ST_LOAD1:
            begin
                raddr0 = s20_pkg::qidx(quarter_reg, 2'd2);
                raddr1 = s20_pkg::qidx(quarter_reg, 2'd3);
            end
            ST_STEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = s20_pkg::qidx(quarter_reg, target);
                mem_wdata = arx_out;
            end
            default:
            begin
            end
        endcase
    end

    // working words
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    // quarter round operands and finished keystream
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD1:
            begin
                qa_reg <= rdata0_reg;
                qb_reg <= rdata1_reg;
            end
            ST_LOAD2:
            begin
                qc_reg <= rdata0_reg;
                qd_reg <= rdata1_reg;
            end
            ST_STEP:
            begin
                unique case (target)
                    2'd0:    qa_reg <= arx_out;
                    2'd1:    qb_reg <= arx_out;
                    2'd2:    qc_reg <= arx_out;
                    default: qd_reg <= arx_out;
                endcase
            end
            ST_FF_WR:
            begin
                ks_reg[idx_reg] <= rdata0_reg + s20_pkg::init_word(idx_reg, cfg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            idx_reg     <= 4'd0;
            quarter_reg <= 3'd0;
            step_reg    <= 2'd0;
            round_reg   <= 4'd0;
        end
        else if (start)
        begin
            state_reg <= ST_INIT;
            idx_reg   <= 4'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_INIT:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg == 4'd15)
                    begin
                        quarter_reg <= 3'd0;
                        step_reg    <= 2'd0;
                        round_reg   <= 4'd0;
                        state_reg   <= (cfg.rounds == 4'd0) ? ST_FF_RD : ST_LOAD0;
                    end
                end
                ST_LOAD0:
                begin
                    state_reg <= ST_LOAD1;
                end
                ST_LOAD1:
                begin
                    state_reg <= ST_LOAD2;
                end
                ST_LOAD2:
                begin
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        quarter_reg <= quarter_reg + 3'd1;
                        if (quarter_reg == 3'd7)
                        begin
                            if (round_reg + 4'd1 == cfg.rounds)
                            begin
                                state_reg <= ST_FF_RD;
                            end
                            else
                            begin
                                round_reg <= round_reg + 4'd1;
                                state_reg <= ST_LOAD0;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_LOAD0;
                        end
                    end
                end
                ST_FF_RD:
                begin
                    state_reg <= ST_FF_WR;
                end
                ST_FF_WR:
                begin
                    idx_reg   <= idx_reg + 4'd1;
                    state_reg <= (idx_reg == 4'd15) ? ST_DONE : ST_FF_RD;
                end
                default:
                begin
                    state_reg <= ST_DONE;
                end
            endcase
        end
    end

endmodule

/* hdl/salsa20_128_stream_cipher.sv */
// salsa20 stream cipher, 128-bit key: configuration, byte position and result word
// depends on s20_pkg and s20_core
//
//   channel   signals                                   direction
//   data      data_valid data_stall data_byte last_in_burst   in
//   result    result_valid result_stall result_byte
//             next_position burst_end                          out
//   config    cfg_write cfg_index cfg_data                     in
//
// one word per cycle while a keystream block is ready and no held result word is stalled
// the 64th byte of a block and every write to index 0 to 4 start a new block, built
// word by word through the one add-rotate-xor unit and the single write port of the
// working-word memory
// after reset the block for position zero is built first, data_stall high meanwhile
// a held result word stalls the data side only when a new word would overwrite it

module salsa20_128_stream_cipher
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               data_valid,
    output logic                               data_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               last_in_burst,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [7:0]                         result_byte,
    output logic [63:0]                        next_position,
    output logic                               burst_end,
    input  logic                               cfg_write,
    input  logic [s20_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [s20_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [63:0] nonce_reg;
    logic [3:0]  rounds_reg;
    logic [63:0] start_position_reg;
    logic [63:0] block_counter_reg;
    logic [5:0]  byte_offset_reg;
    logic        result_valid_reg;
    logic [7:0]  result_byte_reg;
    logic [63:0] next_position_reg;
    logic        burst_end_reg;

    s20_pkg::block_cfg_t core_cfg;
    s20_pkg::ks_block_t  ks;
    logic        core_done;
    logic        core_start;
    logic        accept;
    logic        cfg_valid;
    logic        wrap;
    logic [63:0] sp;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;
    logic [5:0]  offset_next;
    logic [63:0] counter_next;

    assign core_cfg.key_low  = key_low_reg;
    assign core_cfg.key_high = key_high_reg;
    assign core_cfg.nonce    = nonce_reg;
    assign core_cfg.counter  = block_counter_reg;
    assign core_cfg.rounds   = rounds_reg;

    assign data_stall = !(core_done && (!result_valid_reg || !result_stall));
    assign accept     = data_valid && !data_stall;
    assign cfg_valid  = cfg_write && (cfg_index <= s20_pkg::REG_START_POSITION);
    assign wrap       = (byte_offset_reg == 6'h3f);
    assign core_start = cfg_valid || (accept && wrap);
    assign sp         = (cfg_index == s20_pkg::REG_START_POSITION) ? cfg_data
                                                                  : start_position_reg;

    assign ks_word      = ks[byte_offset_reg[5:2]];
    assign ks_byte      = ks_word[{byte_offset_reg[1:0], 3'b000} +: 8];
    assign offset_next  = byte_offset_reg + 6'd1;
    assign counter_next = wrap ? block_counter_reg + 64'd1 : block_counter_reg;

    assign result_valid  = result_valid_reg;
    assign result_byte   = result_byte_reg;
    assign next_position = next_position_reg;
    assign burst_end     = burst_end_reg;

    s20_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .cfg   (core_cfg),
        .ks    (ks),
        .done  (core_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg        <= 64'd0;
            key_high_reg       <= 64'd0;
            nonce_reg          <= 64'd0;
            rounds_reg         <= s20_pkg::DOUBLE_ROUNDS_RESET;
            start_position_reg <= 64'd0;
            block_counter_reg  <= 64'd0;
            byte_offset_reg    <= 6'd0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    s20_pkg::REG_KEY_LOW:       key_low_reg        <= cfg_data;
                    s20_pkg::REG_KEY_HIGH:      key_high_reg       <= cfg_data;
                    s20_pkg::REG_NONCE_VALUE:   nonce_reg          <= cfg_data;
                    s20_pkg::REG_DOUBLE_ROUNDS: rounds_reg         <= cfg_data[3:0];
                    default:                    start_position_reg <= cfg_data;
                endcase
                block_counter_reg <= {6'd0, sp[63:6]};
                byte_offset_reg   <= sp[5:0];
            end
            else if (accept)
            begin
                byte_offset_reg   <= offset_next;
                block_counter_reg <= counter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_byte_reg   <= data_byte ^ ks_byte;
            next_position_reg <= {counter_next[57:0], offset_next};
            burst_end_reg     <= last_in_burst;
        end
    end

endmodule

/* hdl/s20_checker.sv */
// port-level checks for salsa20_128_stream_cipher, attached by bind
// depends on s20_pkg and the top level's ports

module s20_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            data_valid,
    input logic                            data_stall,
    input logic                            last_in_burst,
    input logic                            result_valid,
    input logic                            result_stall,
    input logic                            burst_end,
    input logic                            cfg_write,
    input logic [s20_pkg::CFG_INDEX_W-1:0] cfg_index
);

    // a held result word stays
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    // an accepted word shows up as a result next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && !data_stall |=> result_valid)
        else $error("accepted word gave no result");

    // burst marker follows its word
    a_burst_echo: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && !data_stall |=> burst_end == $past(last_in_burst))
        else $error("burst_end does not match accepted word");

    // a write to a used register index rebuilds the block, so the data side must stall
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index <= s20_pkg::REG_START_POSITION) |=> data_stall)
        else $error("data accepted right after a register write");

endmodule

bind salsa20_128_stream_cipher s20_checker u_s20_checker (.*);

/* test/salsa20_128_stream_cipher_test.sv */
// testbench for salsa20_128_stream_cipher: byte words with random gaps and stalls
// a keystream predictor of its own checks every result word in order
// depends on s20_pkg and the rtl of salsa20_128_stream_cipher

module salsa20_128_stream_cipher_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REGEN_WAIT   = 1000;
    localparam int DRAIN_WAIT   = 64;
    localparam int RANDOM_WORDS = 1100;
    localparam int STEADY_WORDS = 200;

    typedef logic [15:0][31:0] state_words_t;
    typedef logic [s20_pkg::CFG_INDEX_W-1:0] cfg_index_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [63:0] next_position;
        logic        burst_end;
    } cipher_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            data_valid;
    logic                            data_stall;
    logic [7:0]                      data_byte;
    logic                            last_in_burst;
    logic                            result_valid;
    logic                            result_stall;
    logic [7:0]                      result_byte;
    logic [63:0]                     next_position;
    logic                            burst_end;
    logic                            cfg_write;
    cfg_index_t                      cfg_index;
    logic [s20_pkg::CFG_DATA_W-1:0]  cfg_data;

    logic [63:0]  key_lo_q;
    logic [63:0]  key_hi_q;
    logic [63:0]  nonce_q;
    logic [63:0]  start_q;
    logic [63:0]  counter_q;
    logic [3:0]   rounds_q;
    logic [5:0]   offset_q;
    state_words_t keystream_q;

    cipher_word_t expected_words[$];
    int           error_count = 0;
    bit           idling = 1'b1;

    salsa20_128_stream_cipher u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_stall    (data_stall),
        .data_byte     (data_byte),
        .last_in_burst (last_in_burst),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_byte   (result_byte),
        .next_position (next_position),
        .burst_end     (burst_end),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic state_words_t quarter_round(input state_words_t w,
                                                   input int a, input int b,
                                                   input int c, input int d);
        w[b] = w[b] ^ rotate_left(w[a] + w[d], 7);
        w[c] = w[c] ^ rotate_left(w[b] + w[a], 9);
        w[d] = w[d] ^ rotate_left(w[c] + w[b], 13);
        w[a] = w[a] ^ rotate_left(w[d] + w[c], 18);
        return w;
    endfunction

    function automatic state_words_t salsa_block(input logic [63:0] counter);
        state_words_t init;
        state_words_t mix;
        init[0]  = s20_pkg::TAU0;
        init[1]  = key_lo_q[31:0];
        init[2]  = key_lo_q[63:32];
        init[3]  = key_hi_q[31:0];
        init[4]  = key_hi_q[63:32];
        init[5]  = s20_pkg::TAU1;
        init[6]  = nonce_q[31:0];
        init[7]  = nonce_q[63:32];
        init[8]  = counter[31:0];
        init[9]  = counter[63:32];
        init[10] = s20_pkg::TAU2;
        init[11] = key_lo_q[31:0];
        init[12] = key_lo_q[63:32];
        init[13] = key_hi_q[31:0];
        init[14] = key_hi_q[63:32];
        init[15] = s20_pkg::TAU3;
        mix = init;
        for (int r = 0; r < rounds_q; r++)
        begin
            mix = quarter_round(mix, 0, 4, 8, 12);
            mix = quarter_round(mix, 5, 9, 13, 1);
            mix = quarter_round(mix, 10, 14, 2, 6);
            mix = quarter_round(mix, 15, 3, 7, 11);
            mix = quarter_round(mix, 0, 1, 2, 3);
            mix = quarter_round(mix, 5, 6, 7, 4);
            mix = quarter_round(mix, 10, 11, 8, 9);
            mix = quarter_round(mix, 15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++)
            mix[i] = mix[i] + init[i];
        return mix;
    endfunction

    function automatic void reload_position();
        counter_q   = start_q >> 6;
        offset_q    = start_q[5:0];
        keystream_q = salsa_block(counter_q);
    endfunction

    function automatic void apply_register(input cfg_index_t idx,
                                           input logic [63:0] value);
        case (idx)
            s20_pkg::REG_KEY_LOW:        key_lo_q = value;
            s20_pkg::REG_KEY_HIGH:       key_hi_q = value;
            s20_pkg::REG_NONCE_VALUE:    nonce_q  = value;
            s20_pkg::REG_DOUBLE_ROUNDS:  rounds_q = value[3:0];
            s20_pkg::REG_START_POSITION: start_q  = value;
            default:                     return;
        endcase
        reload_position();
    endfunction

    function automatic void predict_word(input logic [7:0] value, input logic last);
        cipher_word_t w;
        w.result_byte = value ^ keystream_q[offset_q[5:2]][8 * offset_q[1:0] +: 8];
        w.burst_end   = last;
        offset_q      = offset_q + 6'd1;
        if (offset_q == 6'd0)
        begin
            counter_q   = counter_q + 64'd1;
            keystream_q = salsa_block(counter_q);
        end
        w.next_position = {counter_q[57:0], offset_q};
        expected_words.push_back(w);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [7:0] value, input logic last);
        if (idling && $urandom_range(5) == 0)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        data_valid    <= 1'b1;
        data_byte     <= value;
        last_in_burst <= last;
        do
            @(posedge clk);
        while (data_stall);
        predict_word(value, last);
        @(negedge clk);
    endtask

    task automatic wait_quiet(input int cycles);
        data_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (cycles) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        wait_quiet(REGEN_WAIT);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        apply_register(idx, value);
    endtask

    function automatic logic [63:0] random_value(input cfg_index_t idx);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case (idx)
            s20_pkg::REG_DOUBLE_ROUNDS:
                if ($urandom_range(3) != 0)
                    v = 64'($urandom_range(0, 15));
            s20_pkg::REG_START_POSITION:
                case ($urandom_range(2))
                    0:       v = 64'($urandom_range(0, 300));
                    1:       v = {58'h3FF_FFFF_FFFF_FFFF, 6'($urandom)}
                                 - 64'(64 * $urandom_range(0, 2));
                    default: v = {$urandom, $urandom};
                endcase
            default:
                case ($urandom_range(7))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = {$urandom, $urandom};
                endcase
        endcase
        return v;
    endfunction

    task automatic random_config();
        cfg_index_t idx;
        int         writes;
        writes = $urandom_range(0, 2);
        repeat (writes)
        begin
            if ($urandom_range(9) == 0)
                idx = cfg_index_t'($urandom_range(s20_pkg::REG_START_POSITION + 1,
                                                  2 ** s20_pkg::CFG_INDEX_W - 1));
            else
                idx = cfg_index_t'($urandom_range(s20_pkg::REG_KEY_LOW,
                                                  s20_pkg::REG_START_POSITION));
            write_reg(idx, random_value(idx));
        end
    endtask

    task automatic test_reset_keystream();
        wait_quiet(REGEN_WAIT);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b1);
    endtask

    task automatic test_register_writes();
        write_reg(s20_pkg::REG_KEY_LOW, '1);
        send_word(8'h3C, 1'b1);
        write_reg(s20_pkg::REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
        send_word(8'hC3, 1'b0);
        write_reg(s20_pkg::REG_NONCE_VALUE, '1);
        send_word(8'h81, 1'b1);
        // no rounds: each keystream word is its initial word doubled
        write_reg(s20_pkg::REG_DOUBLE_ROUNDS, 64'd0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        write_reg(s20_pkg::REG_DOUBLE_ROUNDS, 64'd15);
        send_word(8'h7E, 1'b1);
        // upper bits are dropped
        write_reg(s20_pkg::REG_DOUBLE_ROUNDS, 64'hFFFF_FFFF_FFFF_FFF3);
        send_word(8'h18, 1'b0);
        // last byte of block zero, then into block one
        write_reg(s20_pkg::REG_START_POSITION, 64'd63);
        send_word(8'hE7, 1'b0);
        send_word(8'h42, 1'b1);
        // same value again still reloads the position
        write_reg(s20_pkg::REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
        send_word(8'h99, 1'b1);
        // unused indexes leave everything alone
        for (int i = s20_pkg::REG_START_POSITION + 1; i < 2 ** s20_pkg::CFG_INDEX_W; i++)
            write_reg(cfg_index_t'(i), {$urandom, $urandom});
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b1);
    endtask

    task automatic test_counter_wrap();
        write_reg(s20_pkg::REG_START_POSITION, 64'hFFFF_FFFF_FFFF_FFFE);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h0F, 1'b0);
        send_word(8'hF0, 1'b1);
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        int burst;
        int call_len;
        logic last;
        sent = 0;
        while (sent < count)
        begin
            random_config();
            if ($urandom_range(7) == 0)
                burst = $urandom_range(120, 200);
            else
                burst = $urandom_range(1, 80);
            call_len = 0;
            for (int i = 0; i < burst; i++)
            begin
                if (call_len == 0)
                    call_len = $urandom_range(1, 40);
                call_len--;
                last = (call_len == 0) || (i == burst - 1);
                if ($urandom_range(31) == 0)
                    last = !last;
                send_word(8'($urandom_range(255)), last);
            end
            sent += burst;
        end
    endtask

    task automatic test_steady_stream();
        idling = 1'b0;
        test_random_traffic(STEADY_WORDS);
    endtask

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                result_stall <= 1'b0;
            end
            else if ($urandom_range(31) == 0)
            begin
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        cipher_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: result_byte %h", result_byte);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (result_byte !== want.result_byte)
                begin
                    $error("result_byte expected %h actual %h", want.result_byte, result_byte);
                    error_count++;
                end
                if (next_position !== want.next_position)
                begin
                    $error("next_position expected %h actual %h",
                           want.next_position, next_position);
                    error_count++;
                end
                if (burst_end !== want.burst_end)
                begin
                    $error("burst_end expected %b actual %b", want.burst_end, burst_end);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        data_valid    = 1'b0;
        data_byte     = '0;
        last_in_burst = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        key_lo_q      = '0;
        key_hi_q      = '0;
        nonce_q       = '0;
        start_q       = '0;
        rounds_q      = s20_pkg::DOUBLE_ROUNDS_RESET;
        reload_position();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_keystream();
        test_register_writes();
        test_counter_wrap();
        test_random_traffic(RANDOM_WORDS);
        test_steady_stream();

        wait_quiet(DRAIN_WAIT);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hdl/s20_pkg.sv
hdl/s20_arx.sv
hdl/s20_core.sv
hdl/salsa20_128_stream_cipher.sv
hdl/s20_checker.sv
test/salsa20_128_stream_cipher_test.sv
